@@ rtl/cgs_pkg.sv @@
// ----------------------------------------------------------------------------
// cgs_pkg: shared types and constants of the color gradient sampler
// Stop entry layout, result status codes, sequencer states and the
// position clamp used at request intake.
// ----------------------------------------------------------------------------
package cgs_pkg;

  localparam int POS_W = 13;            // unsigned Q1.12 stored position
  localparam int IN_POS_W = 14;         // signed Q1.12 request position
  localparam int CH_W = 8;              // one color channel
  localparam int COL_W = 4 * CH_W;      // packed RGBA, red in the low byte
  localparam int ACC_W = 20;            // weighted channel sum, at most 255 * 4096
  localparam int MUL_W = CH_W + POS_W;  // raw product width
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(4096);

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [COL_W-1:0] color;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_CMP,
    S_ADD_PUT,
    S_SMP_LAST,
    S_SMP_FIRST,
    S_SMP_SCAN,
    S_SMP_INTERP,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    IX_IDLE,
    IX_MUL_LO,
    IX_MUL_HI,
    IX_DIV,
    IX_DONE
  } interp_state_t;

  // Saturate a signed Q1.12 position to 0..1.0
  function automatic logic [POS_W-1:0] clamp_pos(input logic [IN_POS_W-1:0] raw);
    logic [POS_W-1:0] mag;
    mag = raw[POS_W-1:0];
    if (raw[IN_POS_W-1]) begin
      return '0;
    end else if (mag > POS_ONE) begin
      return POS_ONE;
    end
    return mag;
  endfunction

endpackage

@@ rtl/cgs_interp.sv @@
// ----------------------------------------------------------------------------
// cgs_interp: serial channel interpolator
// Blends four color channels one at a time with a shared 8x13 multiplier
// and a restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cgs_interp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cgs_pkg::POS_W-1:0]   wlo,
  input  logic [cgs_pkg::POS_W-1:0]   whi,
  input  logic [cgs_pkg::POS_W-1:0]   den,
  input  logic [cgs_pkg::COL_W-1:0]   lo_color,
  input  logic [cgs_pkg::COL_W-1:0]   hi_color,
  output logic                        done,
  output logic [cgs_pkg::COL_W-1:0]   color
);
  import cgs_pkg::*;

  interp_state_t state, state_next;

  logic [POS_W-1:0] wlo_r, whi_r, den_r;
  logic [COL_W-1:0] lo_r, hi_r;
  logic [1:0]       ch;
  logic [2:0]       bitc;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] dsr;
  logic [CH_W-1:0]  qt;

  logic [CH_W-1:0]  mul_a;
  logic [POS_W-1:0] mul_b;
  logic [MUL_W-1:0] prod;
  logic             qbit;
  logic             last_bit;

  // Shared multiplier: low stop weight first, then high stop weight
  always_comb begin
    if (state == IX_MUL_HI) begin
      mul_a = hi_r[ch*CH_W +: CH_W];
      mul_b = whi_r;
    end else begin
      mul_a = lo_r[ch*CH_W +: CH_W];
      mul_b = wlo_r;
    end
    prod = MUL_W'(mul_a) * MUL_W'(mul_b);
  end

  // One restoring division step
  assign qbit = (acc >= dsr);
  assign last_bit = (bitc == 3'd0);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      IX_IDLE:   if (start) state_next = IX_MUL_LO;
      IX_MUL_LO: state_next = IX_MUL_HI;
      IX_MUL_HI: state_next = IX_DIV;
      IX_DIV: begin
        if (last_bit) begin
          state_next = (ch == 2'd3) ? IX_DONE : IX_MUL_LO;
        end
      end
      IX_DONE:   state_next = IX_IDLE;
      default:   state_next = IX_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done = (state == IX_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IX_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: latch operands, accumulate, divide, store channel
  always_ff @(posedge clk) begin
    case (state)
      IX_IDLE: begin
        if (start) begin
          wlo_r <= wlo;
          whi_r <= whi;
          den_r <= den;
          lo_r <= lo_color;
          hi_r <= hi_color;
          ch <= 2'd0;
        end
      end
      IX_MUL_LO: begin
        acc <= ACC_W'(prod);
      end
      IX_MUL_HI: begin
        acc <= acc + ACC_W'(prod);
        dsr <= {den_r, 7'd0};
        bitc <= 3'd7;
      end
      IX_DIV: begin
        if (qbit) begin
          acc <= acc - dsr;
        end
        qt <= {qt[CH_W-2:0], qbit};
        dsr <= dsr >> 1;
        bitc <= bitc - 3'd1;
        if (last_bit) begin
          color[ch*CH_W +: CH_W] <= {qt[CH_W-2:0], qbit};
          ch <= ch + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/color_gradient_sampler.sv @@
// ----------------------------------------------------------------------------
// color_gradient_sampler: piecewise linear RGBA gradient
// Sorted table of color stops with insert and sample requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall): func 0 inserts a stop at the
//   clamped position after any stops of equal position; func 1 samples.
//   Result channel (res_valid / res_stall): one result per request, four
//   channels and a status (ok, table full, empty table sampled).
//   The block works on one request at a time and raises req_stall until the
//   request's result sits in the output register. The output register lets
//   a new request be taken while the previous result is still stalled.
//   Insert: the stops above the new position are moved up by one slot,
//   top first (read and write in the same cycle), then the new stop is
//   written; a full table is reported without a table walk.
//   Sample: two reads for the end stops, then one read per stop scanned
//   (up to MAX_STOPS - 1), then four channels in the serial interpolator
//   (two multiply steps and eight divide steps per channel), then the
//   color is handed back; an end stop decides the color without the
//   interpolator, and an empty table is reported without a table walk.
//   Reset empties the table (count to zero) and drops any pending result.
//   When the receiver stalls, the result holds and the next request's result
//   waits in the sequencer's final state.
// ----------------------------------------------------------------------------
module color_gradient_sampler #(
  parameter int MAX_STOPS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          func,
  input  logic [cgs_pkg::IN_POS_W-1:0]  position,
  input  logic [cgs_pkg::CH_W-1:0]      red_in,
  input  logic [cgs_pkg::CH_W-1:0]      green_in,
  input  logic [cgs_pkg::CH_W-1:0]      blue_in,
  input  logic [cgs_pkg::CH_W-1:0]      alpha_in,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [cgs_pkg::CH_W-1:0]      red_out,
  output logic [cgs_pkg::CH_W-1:0]      green_out,
  output logic [cgs_pkg::CH_W-1:0]      blue_out,
  output logic [cgs_pkg::CH_W-1:0]      alpha_out,
  output logic [1:0]                    status
);
  import cgs_pkg::*;

  localparam int AW = $clog2(MAX_STOPS);
  localparam int CW = $clog2(MAX_STOPS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_STOPS);

  state_t state, state_next;

  // Stop table
  entry_t mem [MAX_STOPS];
  entry_t mem_q;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  entry_t mem_wdata;
  logic mem_we;

  logic [CW-1:0]    count;
  logic [AW-1:0]    slot;
  logic [AW-1:0]    idx;
  logic [POS_W-1:0] p;
  logic [COL_W-1:0] new_color;
  entry_t           last_e;
  entry_t           prev_e;
  logic [COL_W-1:0] res_color;
  logic [1:0]       res_st;

  logic             accept;
  logic [POS_W-1:0] p_in;
  logic [AW-1:0]    cnt_m1;
  logic             shift_up;
  logic             out_free;
  logic             hit;

  logic             ix_start;
  logic             ix_done;
  logic [COL_W-1:0] ix_color;
  logic [POS_W-1:0] ix_wlo, ix_whi, ix_den;

  assign req_stall = (state != S_IDLE);
  assign accept = req_valid && !req_stall;
  assign p_in = clamp_pos(position);
  assign cnt_m1 = AW'(count - CW'(1));
  assign shift_up = (mem_q.pos > p);
  assign out_free = !res_valid || !res_stall;
  assign hit = (mem_q.pos >= p);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (func == FUNC_ADD) begin
            if (count == CNT_MAX) begin
              state_next = S_FIN;
            end else if (count == '0) begin
              state_next = S_ADD_PUT;
            end else begin
              state_next = S_ADD_CMP;
            end
          end else begin
            state_next = (count == '0) ? S_FIN : S_SMP_LAST;
          end
        end
      end
      S_ADD_CMP: begin
        if (!shift_up) begin
          state_next = S_FIN;
        end else if (slot == AW'(1)) begin
          state_next = S_ADD_PUT;
        end
      end
      S_ADD_PUT:   state_next = S_FIN;
      S_SMP_LAST:  state_next = S_SMP_FIRST;
      S_SMP_FIRST: begin
        if (p <= mem_q.pos || p >= last_e.pos) begin
          state_next = S_FIN;
        end else begin
          state_next = S_SMP_SCAN;
        end
      end
      S_SMP_SCAN:   if (hit) state_next = S_SMP_INTERP;
      S_SMP_INTERP: if (ix_done) state_next = S_FIN;
      S_FIN:        if (out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // Memory port and interpolator control
  always_comb begin
    mem_raddr = '0;
    mem_waddr = slot;
    mem_wdata = '{pos: p, color: new_color};
    mem_we = 1'b0;
    ix_start = 1'b0;
    ix_wlo = mem_q.pos - p;
    ix_whi = p - prev_e.pos;
    ix_den = mem_q.pos - prev_e.pos;
    case (state)
      S_IDLE: begin
        mem_raddr = cnt_m1;
      end
      S_ADD_CMP: begin
        mem_we = 1'b1;
        if (shift_up) begin
          mem_wdata = mem_q;
          mem_raddr = slot - AW'(2);
        end
      end
      S_ADD_PUT: begin
        mem_we = 1'b1;
      end
      S_SMP_LAST: begin
        mem_raddr = '0;
      end
      S_SMP_FIRST: begin
        mem_raddr = AW'(1);
      end
      S_SMP_SCAN: begin
        mem_raddr = idx + AW'(1);
        ix_start = hit;
      end
      default: begin
      end
    endcase
  end

  // Table storage with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Stop count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if ((state == S_ADD_PUT) || (state == S_ADD_CMP && !shift_up)) begin
      count <= count + CW'(1);
    end
  end

  // Request capture, insertion walk and sample scan
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          p <= p_in;
          new_color <= {alpha_in, blue_in, green_in, red_in};
          slot <= count[AW-1:0];
          res_color <= '0;
          res_st <= ST_OK;
          if (func == FUNC_ADD) begin
            if (count == CNT_MAX) res_st <= ST_FULL;
          end else if (count == '0) begin
            res_color <= '1;
            res_st <= ST_EMPTY;
          end
        end
      end
      S_ADD_CMP: begin
        if (shift_up) slot <= slot - AW'(1);
      end
      S_ADD_PUT: begin
        slot <= '0;
      end
      S_SMP_LAST: begin
        last_e <= mem_q;
      end
      S_SMP_FIRST: begin
        if (p <= mem_q.pos) begin
          res_color <= mem_q.color;
        end else if (p >= last_e.pos) begin
          res_color <= last_e.color;
        end else begin
          prev_e <= mem_q;
          idx <= AW'(1);
        end
      end
      S_SMP_SCAN: begin
        if (!hit) begin
          prev_e <= mem_q;
          idx <= idx + AW'(1);
        end
      end
      S_SMP_INTERP: begin
        if (ix_done) res_color <= ix_color;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      red_out <= res_color[0*CH_W +: CH_W];
      green_out <= res_color[1*CH_W +: CH_W];
      blue_out <= res_color[2*CH_W +: CH_W];
      alpha_out <= res_color[3*CH_W +: CH_W];
      status <= res_st;
    end
  end

  cgs_interp u_interp (
    .clk      (clk),
    .rst      (rst),
    .start    (ix_start),
    .wlo      (ix_wlo),
    .whi      (ix_whi),
    .den      (ix_den),
    .lo_color (prev_e.color),
    .hi_color (mem_q.color),
    .done     (ix_done),
    .color    (ix_color)
  );

`ifndef SYNTHESIS
  // Table never holds more stops than it has slots
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("stop count above table depth");

  // Count only grows, and by one stop at a time
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + CW'(1)))
    else $error("stop count changed by more than one");

  // Empty table sample returns white
  a_empty_white: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == ST_EMPTY) |->
      (red_out == 8'hFF && green_out == 8'hFF && blue_out == 8'hFF && alpha_out == 8'hFF))
    else $error("empty table result is not white");

  // A full table report carries no color
  a_full_black: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == ST_FULL) |->
      (red_out == '0 && green_out == '0 && blue_out == '0 && alpha_out == '0))
    else $error("dropped insert returned a color");
`endif

endmodule
